/* rtl/core/smc_pkg.sv */
// Shared types and constants for the stack machine core.
// Item structs, request kinds, status codes and opcodes; no dependencies.
package smc_pkg;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] addr;
    logic [15:0] load_value;
    logic [15:0] in_value;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] read_data;
    logic        out_valid;
    logic        out_port;
    logic [15:0] out_index;
    logic [15:0] out_value;
    logic        in_taken;
    logic        in_port;
    logic [15:0] in_index;
    logic [15:0] pc;
    logic [15:0] stack_top_addr;
    logic [15:0] top_word;
  } rsp_t;

  localparam logic [1:0] REQ_LOAD = 2'd0;
  localparam logic [1:0] REQ_READ = 2'd1;
  localparam logic [1:0] REQ_STEP = 2'd2;

  localparam logic [2:0] ST_RUN    = 3'd0;
  localparam logic [2:0] ST_HALT   = 3'd1;
  localparam logic [2:0] ST_DIVZ   = 3'd2;
  localparam logic [2:0] ST_BADIN  = 3'd3;
  localparam logic [2:0] ST_BADOUT = 3'd4;

  localparam logic [15:0] OP_HALT  = 16'h0000;
  localparam logic [15:0] OP_PUSH  = 16'h0001;
  localparam logic [15:0] OP_PUSHI = 16'h0002;
  localparam logic [15:0] OP_PUSHR = 16'h0003;
  localparam logic [15:0] OP_PUSHA = 16'h0004;
  localparam logic [15:0] OP_PUSHO = 16'h0005;
  localparam logic [15:0] OP_PUSHF = 16'h0006;
  localparam logic [15:0] OP_PUSHS = 16'h0007;
  localparam logic [15:0] OP_PUSHP = 16'h0008;
  localparam logic [15:0] OP_PUSHZ = 16'h0009;
  localparam logic [15:0] OP_DUP   = 16'h000A;
  localparam logic [15:0] OP_POPA  = 16'h0100;
  localparam logic [15:0] OP_POPI  = 16'h0101;
  localparam logic [15:0] OP_POPR  = 16'h0102;
  localparam logic [15:0] OP_POPO  = 16'h0103;
  localparam logic [15:0] OP_POPF  = 16'h0104;
  localparam logic [15:0] OP_POPS  = 16'h0105;
  localparam logic [15:0] OP_DROP  = 16'h0106;
  localparam logic [15:0] OP_SWAP  = 16'h0107;
  localparam logic [15:0] OP_BRA   = 16'h0200;
  localparam logic [15:0] OP_BRI   = 16'h0201;
  localparam logic [15:0] OP_BRZ   = 16'h0300;
  localparam logic [15:0] OP_BNZ   = 16'h0301;
  localparam logic [15:0] OP_BSR   = 16'h0400;
  localparam logic [15:0] OP_RTS   = 16'h0401;
  localparam logic [15:0] OP_EQL   = 16'h0500;
  localparam logic [15:0] OP_NEQ   = 16'h0501;
  localparam logic [15:0] OP_LES   = 16'h0502;
  localparam logic [15:0] OP_LEQ   = 16'h0503;
  localparam logic [15:0] OP_GRE   = 16'h0504;
  localparam logic [15:0] OP_GEQ   = 16'h0505;
  localparam logic [15:0] OP_ADD   = 16'h0600;
  localparam logic [15:0] OP_INC   = 16'h06F0;
  localparam logic [15:0] OP_SUB   = 16'h0700;
  localparam logic [15:0] OP_DEC   = 16'h07F0;
  localparam logic [15:0] OP_MUL   = 16'h0800;
  localparam logic [15:0] OP_DIV   = 16'h0900;
  localparam logic [15:0] OP_MOD   = 16'h09F0;
  localparam logic [15:0] OP_SHL   = 16'h0A00;
  localparam logic [15:0] OP_SHR   = 16'h0B00;
  localparam logic [15:0] OP_IOR   = 16'h0C00;
  localparam logic [15:0] OP_XOR   = 16'h0D00;
  localparam logic [15:0] OP_AND   = 16'h0E00;
  localparam logic [15:0] OP_NOT   = 16'h0F00;
  localparam logic [15:0] OP_IN    = 16'h1000;
  localparam logic [15:0] OP_OUT   = 16'h2000;

endpackage

/* rtl/core/smc_div.sv */
// Iterative 16-bit unsigned divider, one quotient bit per cycle.
// Standalone; used by stack_machine_core for DIV and MOD.
module smc_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [15:0] quotient,
  output logic [15:0] remainder
);

  logic        run;
  logic [4:0]  cnt;
  logic [15:0] rem;
  logic [15:0] quo;
  logic [15:0] dvs;
  logic [16:0] trial;

  assign trial     = {rem, quo[15]} - {1'b0, dvs};
  assign done      = run && (cnt == 5'd0);
  assign quotient  = quo;
  assign remainder = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      cnt <= 5'd0;
    end else if (start) begin
      run <= 1'b1;
      cnt <= 5'd16;
      rem <= 16'd0;
      quo <= dividend;
      dvs <= divisor;
    end else if (run) begin
      if (cnt == 5'd0) begin
        run <= 1'b0;
      end else begin
        cnt <= cnt - 5'd1;
        if (!trial[16]) begin
          rem <= trial[15:0];
          quo <= {quo[14:0], 1'b1};
        end else begin
          rem <= {rem[14:0], quo[15]};
          quo <= {quo[14:0], 1'b0};
        end
      end
    end
  end

endmodule

/* rtl/core/stack_machine_core.sv */
// Top level of the 16-bit stack machine core: word memory and sequencer.
// Depends on smc_pkg and smc_div.
//
//   channel | valid     | stall     | payload
//   request | req_valid | req_stall | req (smc_pkg::req_t)
//   result  | rsp_valid | rsp_stall | rsp (smc_pkg::rsp_t)
//
// Item timing is set by the single memory port and, for DIV or MOD, by the
// bit-serial divider; how long a step takes depends on its opcode.
// After reset a pass clears all 2^ADDR_WIDTH words of memory, one word a cycle;
// req_stall stays high meanwhile. A new item is taken while a result waits.
module stack_machine_core #(
  parameter int ADDR_WIDTH = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  smc_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output smc_pkg::rsp_t rsp
);
  import smc_pkg::*;

  localparam int AW    = ADDR_WIDTH;
  localparam int DEPTH = 1 << AW;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RDQ, S_OP, S_T, S_S, S_S2, S_SW,
    S_ARG1, S_ARG2, S_IX, S_X, S_V, S_DIV, S_TOP, S_DONE
  } state_t;

  logic [15:0] mem [DEPTH];
  logic [15:0] q;
  logic        re, we;
  logic [AW-1:0] ra, wa;
  logic [15:0] wd;

  state_t state, state_next;
  logic [AW-1:0] ip, ip_next, sp, sp_next, fp, fp_next, w3, w3_next, clr_cnt;
  logic [2:0]  stat, stat_next;
  logic [15:0] op, op_next, w1, w1_next, inv;
  logic [15:0] rdata, rdata_next, oidx, oidx_next, oval, oval_next, iidx, iidx_next;
  logic        ov, ov_next, oport, oport_next, it, it_next, iport, iport_next;
  logic        rsp_load, div_start, div_done, acc;
  logic [15:0] quo, rem;
  logic [AW-1:0] sp_m1, sp_p1, sp_p2, sp_p3, ip_p1, ip_p2, ip_p3, ix_addr;
  logic [15:0] ix_sum;
  logic [31:0] prod;

  assign acc       = req_valid && !req_stall;
  assign req_stall = (state != S_IDLE);
  assign sp_m1 = sp - 1'b1;
  assign sp_p1 = sp + 1'b1;
  assign sp_p2 = sp + AW'(2);
  assign sp_p3 = sp + AW'(3);
  assign ip_p1 = ip + 1'b1;
  assign ip_p2 = ip + AW'(2);
  assign ip_p3 = ip + AW'(3);
  assign ix_sum  = w1 + q;
  assign ix_addr = ix_sum[AW-1:0];
  assign prod    = q * w1;

  smc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (q),
    .divisor   (w1),
    .done      (div_done),
    .quotient  (quo),
    .remainder (rem)
  );

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (re) q <= mem[ra];
  end

  always_comb begin
    state_next = state;
    ip_next = ip; sp_next = sp; fp_next = fp; stat_next = stat;
    op_next = op; w1_next = w1; w3_next = w3;
    rdata_next = rdata; ov_next = ov; oport_next = oport; oidx_next = oidx;
    oval_next = oval; it_next = it; iport_next = iport; iidx_next = iidx;
    re = 1'b0; ra = '0; we = 1'b0; wa = '0; wd = '0;
    div_start = 1'b0; rsp_load = 1'b0;
    case (state)
      S_CLEAR: begin
        we = 1'b1; wa = clr_cnt; wd = 16'd0;
        if (clr_cnt == '1) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (acc) begin
          rdata_next = '0; ov_next = 1'b0; oport_next = 1'b0; oidx_next = '0;
          oval_next = '0; it_next = 1'b0; iport_next = 1'b0; iidx_next = '0;
          state_next = S_TOP;
          case (req.req_type)
            REQ_LOAD: begin
              we = 1'b1; wa = req.addr[AW-1:0]; wd = req.load_value;
            end
            REQ_READ: begin
              re = 1'b1; ra = req.addr[AW-1:0]; state_next = S_RDQ;
            end
            REQ_STEP: begin
              if (stat == ST_RUN) begin
                re = 1'b1; ra = ip; state_next = S_OP;
              end
            end
            default: state_next = S_TOP;
          endcase
        end
      end
      S_RDQ: begin
        rdata_next = q; state_next = S_TOP;
      end
      S_OP: begin
        op_next = q;
        state_next = S_TOP;
        case (q)
          OP_HALT: stat_next = ST_HALT;
          OP_PUSH, OP_PUSHA, OP_PUSHI, OP_BRA, OP_BRI, OP_BSR, OP_POPA, OP_POPI: begin
            re = 1'b1; ra = ip_p1; state_next = S_ARG1;
          end
          OP_PUSHF, OP_PUSHS, OP_PUSHP, OP_PUSHZ: begin
            we = 1'b1; wa = sp_m1; sp_next = sp_m1; ip_next = ip_p1;
            wd = (q == OP_PUSHF) ? 16'(fp) : (q == OP_PUSHS) ? 16'(sp) :
                 (q == OP_PUSHP) ? 16'(ip) : 16'd0;
          end
          OP_PUSHR, OP_PUSHO, OP_DUP, OP_POPR, OP_POPO, OP_POPF, OP_POPS, OP_DROP,
          OP_SWAP, OP_BRZ, OP_BNZ, OP_RTS, OP_EQL, OP_NEQ, OP_LES, OP_LEQ, OP_GRE,
          OP_GEQ, OP_ADD, OP_SUB, OP_MUL, OP_INC, OP_DEC, OP_DIV, OP_MOD, OP_SHL,
          OP_SHR, OP_IOR, OP_XOR, OP_AND, OP_NOT, OP_IN, OP_OUT: begin
            re = 1'b1; ra = sp; state_next = S_T;
          end
          default: ip_next = ip_p1;
        endcase
      end
      S_T: begin
        w1_next = q;
        state_next = S_TOP;
        case (op)
          OP_PUSHR: begin re = 1'b1; ra = q[AW-1:0]; state_next = S_X; end
          OP_PUSHO: begin re = 1'b1; ra = fp + q[AW-1:0]; state_next = S_X; end
          OP_DUP: begin
            we = 1'b1; wa = sp_m1; wd = q; sp_next = sp_m1; ip_next = ip_p1;
          end
          OP_POPF: begin fp_next = q[AW-1:0]; sp_next = sp_p1; ip_next = ip_p1; end
          OP_POPS: begin sp_next = q[AW-1:0]; ip_next = ip_p1; end
          OP_DROP: begin sp_next = sp_p1; ip_next = ip_p1; end
          OP_BRZ, OP_BNZ: begin
            sp_next = sp_p1;
            if ((q == 16'd0) == (op == OP_BRZ)) begin
              re = 1'b1; ra = ip_p1; state_next = S_ARG1;
            end else begin
              ip_next = ip_p2;
            end
          end
          OP_RTS: begin sp_next = sp_p1; ip_next = q[AW-1:0]; end
          OP_INC: begin we = 1'b1; wa = sp; wd = q + 16'd1; ip_next = ip_p1; end
          OP_DEC: begin we = 1'b1; wa = sp; wd = q - 16'd1; ip_next = ip_p1; end
          OP_NOT: begin we = 1'b1; wa = sp; wd = ~q; ip_next = ip_p1; end
          OP_DIV, OP_MOD: begin
            if (q == 16'd0) begin
              stat_next = ST_DIVZ; sp_next = sp_p1;
            end else begin
              re = 1'b1; ra = sp_p1; state_next = S_S;
            end
          end
          OP_IN: begin
            if (q == 16'd0) begin
              we = 1'b1; wa = sp; wd = inv; it_next = 1'b1; ip_next = ip_p1;
            end else if (q == 16'd1) begin
              re = 1'b1; ra = sp_p1; state_next = S_S;
            end else begin
              stat_next = ST_BADIN; sp_next = sp_p1;
            end
          end
          OP_OUT: begin
            if (q <= 16'd1) begin
              re = 1'b1; ra = sp_p1; state_next = S_S;
            end else begin
              stat_next = ST_BADOUT; sp_next = sp_p1;
            end
          end
          default: begin re = 1'b1; ra = sp_p1; state_next = S_S; end
        endcase
      end
      S_S: begin
        state_next = S_TOP;
        ip_next = ip_p1;
        case (op)
          OP_POPR: begin we = 1'b1; wa = w1[AW-1:0]; wd = q; sp_next = sp_p2; end
          OP_POPO: begin we = 1'b1; wa = fp + w1[AW-1:0]; wd = q; sp_next = sp_p2; end
          OP_SWAP: begin we = 1'b1; wa = sp; wd = q; ip_next = ip; state_next = S_SW; end
          OP_EQL: begin we = 1'b1; wa = sp_p1; wd = 16'(q == w1); sp_next = sp_p1; end
          OP_NEQ: begin we = 1'b1; wa = sp_p1; wd = 16'(q != w1); sp_next = sp_p1; end
          OP_LES: begin we = 1'b1; wa = sp_p1; wd = 16'(q < w1); sp_next = sp_p1; end
          OP_LEQ: begin we = 1'b1; wa = sp_p1; wd = 16'(q <= w1); sp_next = sp_p1; end
          OP_GRE: begin we = 1'b1; wa = sp_p1; wd = 16'(q > w1); sp_next = sp_p1; end
          OP_GEQ: begin we = 1'b1; wa = sp_p1; wd = 16'(q >= w1); sp_next = sp_p1; end
          OP_ADD: begin we = 1'b1; wa = sp_p1; wd = q + w1; sp_next = sp_p1; end
          OP_SUB: begin we = 1'b1; wa = sp_p1; wd = q - w1; sp_next = sp_p1; end
          OP_MUL: begin we = 1'b1; wa = sp_p1; wd = prod[15:0]; sp_next = sp_p1; end
          OP_SHL: begin
            we = 1'b1; wa = sp_p1; sp_next = sp_p1;
            wd = (w1 >= 16'd16) ? 16'd0 : (q << w1[3:0]);
          end
          OP_SHR: begin
            we = 1'b1; wa = sp_p1; sp_next = sp_p1;
            wd = (w1 >= 16'd16) ? 16'd0 : (q >> w1[3:0]);
          end
          OP_IOR: begin we = 1'b1; wa = sp_p1; wd = q | w1; sp_next = sp_p1; end
          OP_XOR: begin we = 1'b1; wa = sp_p1; wd = q ^ w1; sp_next = sp_p1; end
          OP_AND: begin we = 1'b1; wa = sp_p1; wd = q & w1; sp_next = sp_p1; end
          OP_DIV, OP_MOD: begin div_start = 1'b1; ip_next = ip; state_next = S_DIV; end
          OP_IN: begin
            iidx_next = q; we = 1'b1; wa = sp_p1; wd = inv;
            it_next = 1'b1; iport_next = 1'b1; sp_next = sp_p1;
          end
          OP_OUT: begin
            if (!w1[0]) begin
              oval_next = {8'd0, q[7:0]}; ov_next = 1'b1; sp_next = sp_p2;
            end else begin
              oidx_next = q; re = 1'b1; ra = sp_p2; ip_next = ip; state_next = S_S2;
            end
          end
          default: ip_next = ip;
        endcase
      end
      S_S2: begin
        oval_next = q; ov_next = 1'b1; oport_next = 1'b1;
        sp_next = sp_p3; ip_next = ip_p1; state_next = S_TOP;
      end
      S_SW: begin
        we = 1'b1; wa = sp_p1; wd = w1; ip_next = ip_p1; state_next = S_TOP;
      end
      S_DIV: begin
        if (div_done) begin
          we = 1'b1; wa = sp_p1; wd = (op == OP_DIV) ? quo : rem;
          sp_next = sp_p1; ip_next = ip_p1; state_next = S_TOP;
        end
      end
      S_ARG1: begin
        w1_next = q;
        state_next = S_TOP;
        case (op)
          OP_PUSH: begin
            we = 1'b1; wa = sp_m1; wd = q; sp_next = sp_m1; ip_next = ip_p2;
          end
          OP_PUSHA: begin re = 1'b1; ra = q[AW-1:0]; state_next = S_X; end
          OP_BRA, OP_BRZ, OP_BNZ: ip_next = q[AW-1:0];
          OP_BSR: begin
            we = 1'b1; wa = sp_m1; wd = 16'(ip_p1) + 16'd1;
            sp_next = sp_m1; ip_next = q[AW-1:0];
          end
          OP_POPA: begin w3_next = q[AW-1:0]; re = 1'b1; ra = sp; state_next = S_V; end
          OP_PUSHI, OP_BRI, OP_POPI: begin re = 1'b1; ra = ip_p2; state_next = S_ARG2; end
          default: state_next = S_TOP;
        endcase
      end
      S_ARG2: begin
        re = 1'b1; ra = q[AW-1:0]; state_next = S_IX;
      end
      S_IX: begin
        state_next = S_TOP;
        case (op)
          OP_BRI: ip_next = ix_addr;
          OP_PUSHI: begin re = 1'b1; ra = ix_addr; state_next = S_X; end
          OP_POPI: begin w3_next = ix_addr; re = 1'b1; ra = sp; state_next = S_V; end
          default: state_next = S_TOP;
        endcase
      end
      S_X: begin
        state_next = S_TOP;
        we = 1'b1; wd = q;
        case (op)
          OP_PUSHA: begin wa = sp_m1; sp_next = sp_m1; ip_next = ip_p2; end
          OP_PUSHI: begin wa = sp_m1; sp_next = sp_m1; ip_next = ip_p3; end
          default: begin wa = sp; ip_next = ip_p1; end
        endcase
      end
      S_V: begin
        we = 1'b1; wa = w3; wd = q; sp_next = sp_p1;
        ip_next = (op == OP_POPA) ? ip_p2 : ip_p3;
        state_next = S_TOP;
      end
      S_TOP: begin
        re = 1'b1; ra = sp; state_next = S_DONE;
      end
      S_DONE: begin
        if (!rsp_valid || !rsp_stall) begin
          rsp_load = 1'b1; state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      ip        <= '0;
      sp        <= '1;
      fp        <= '1;
      stat      <= ST_RUN;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_cnt <= clr_cnt + 1'b1;
      ip   <= ip_next;
      sp   <= sp_next;
      fp   <= fp_next;
      stat <= stat_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
    op <= op_next; w1 <= w1_next; w3 <= w3_next;
    rdata <= rdata_next; ov <= ov_next; oport <= oport_next; oidx <= oidx_next;
    oval <= oval_next; it <= it_next; iport <= iport_next; iidx <= iidx_next;
    if (acc) inv <= req.in_value;
    if (rsp_load) begin
      rsp.status         <= stat;
      rsp.read_data      <= rdata;
      rsp.out_valid      <= ov;
      rsp.out_port       <= oport;
      rsp.out_index      <= oidx;
      rsp.out_value      <= oval;
      rsp.in_taken       <= it;
      rsp.in_port        <= iport;
      rsp.in_index       <= iidx;
      rsp.pc             <= 16'(ip);
      rsp.stack_top_addr <= 16'(sp);
      rsp.top_word       <= q;
    end
  end

`ifndef SYNTHESIS
  a_stat_sticky: assert property (@(posedge clk) disable iff (rst)
    (stat != ST_RUN) |=> (stat == $past(stat)))
    else $error("stop status changed");
  a_div_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("divider finished outside its wait state");
  a_ip_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |=> $stable(ip))
    else $error("instruction pointer moved while idle");
  a_no_mem_access_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |-> (!we && !re))
    else $error("memory touched while result is held");
`endif

endmodule

/* dv/stack_machine_core_tb.sv */
// Testbench for stack_machine_core: an exact predictor of the core checks every result item.
// Depends on smc_pkg and the stack_machine_core RTL; each opcode is loaded, then stepped.
module stack_machine_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import smc_pkg::*;

  localparam logic [1:0] REQ_NONE = 2'd3;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  req_valid = 1'b0;
  logic  req_stall;
  req_t  req = '0;
  logic  rsp_valid;
  logic  rsp_stall = 1'b0;
  rsp_t  rsp;

  stack_machine_core u_dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  always #5 clk = ~clk;

  // Predicted machine state
  logic [15:0] mem [0:65535];
  logic [15:0] ip, sp, fp;
  logic [2:0]  run_st;

  req_t pend[$];
  rsp_t expected_rsp[$];
  int   errors = 0;
  bit   hold_request = 1'b0;

  function automatic logic [15:0] rnd16();
    return 16'($urandom);
  endfunction

  function automatic void spush(logic [15:0] v);
    sp = sp - 16'd1;
    mem[sp] = v;
  endfunction

  function automatic logic [15:0] spop();
    logic [15:0] v;
    v = mem[sp];
    sp = sp + 16'd1;
    return v;
  endfunction

  function automatic logic [15:0] next_word();
    ip = ip + 16'd1;
    return mem[ip];
  endfunction

  function automatic logic [15:0] indexed_addr();
    logic [15:0] base, ix;
    base = next_word();
    ix = next_word();
    return base + mem[ix];
  endfunction

  task automatic predict_item(input req_t r, output rsp_t o);
    logic [15:0] op, t, s, a;
    bit adv;
    o = '0;
    adv = 1'b1;
    case (r.req_type)
      REQ_LOAD: mem[r.addr] = r.load_value;
      REQ_READ: o.read_data = mem[r.addr];
      REQ_STEP: if (run_st == ST_RUN) begin
        op = mem[ip];
        case (op)
          OP_HALT: begin run_st = ST_HALT; adv = 1'b0; end
          OP_PUSH: spush(next_word());
          OP_PUSHI: begin a = indexed_addr(); spush(mem[a]); end
          OP_PUSHR: begin a = spop(); spush(mem[a]); end
          OP_PUSHA: begin a = next_word(); spush(mem[a]); end
          OP_PUSHO: begin t = spop(); a = fp + t; spush(mem[a]); end
          OP_PUSHF: spush(fp);
          OP_PUSHS: spush(sp);
          OP_PUSHP: spush(ip);
          OP_PUSHZ: spush(16'd0);
          OP_DUP: spush(mem[sp]);
          OP_POPA: begin t = next_word(); s = spop(); mem[t] = s; end
          OP_POPI: begin t = indexed_addr(); s = spop(); mem[t] = s; end
          OP_POPR: begin t = spop(); s = spop(); mem[t] = s; end
          OP_POPO: begin t = spop(); s = spop(); a = fp + t; mem[a] = s; end
          OP_POPF: fp = spop();
          OP_POPS: begin t = spop(); sp = t; end
          OP_DROP: t = spop();
          OP_SWAP: begin
            a = sp + 16'd1;
            t = mem[sp];
            mem[sp] = mem[a];
            mem[a] = t;
          end
          OP_BRA: begin ip = next_word(); adv = 1'b0; end
          OP_BRI: begin ip = indexed_addr(); adv = 1'b0; end
          OP_BRZ, OP_BNZ: begin
            t = spop();
            if ((t == 16'd0) == (op == OP_BRZ)) ip = next_word();
            else ip = ip + 16'd2;
            adv = 1'b0;
          end
          OP_BSR: begin
            t = next_word();
            spush(ip + 16'd1);
            ip = t;
            adv = 1'b0;
          end
          OP_RTS: begin ip = spop(); adv = 1'b0; end
          OP_EQL: begin t = spop(); s = spop(); spush({15'd0, s == t}); end
          OP_NEQ: begin t = spop(); s = spop(); spush({15'd0, s != t}); end
          OP_LES: begin t = spop(); s = spop(); spush({15'd0, s < t}); end
          OP_LEQ: begin t = spop(); s = spop(); spush({15'd0, s <= t}); end
          OP_GRE: begin t = spop(); s = spop(); spush({15'd0, s > t}); end
          OP_GEQ: begin t = spop(); s = spop(); spush({15'd0, s >= t}); end
          OP_ADD: begin t = spop(); s = spop(); spush(s + t); end
          OP_SUB: begin t = spop(); s = spop(); spush(s - t); end
          OP_MUL: begin t = spop(); s = spop(); spush(s * t); end
          OP_INC: mem[sp] = mem[sp] + 16'd1;
          OP_DEC: mem[sp] = mem[sp] - 16'd1;
          OP_DIV, OP_MOD: begin
            t = spop();
            if (t == 16'd0) begin
              run_st = ST_DIVZ;
              adv = 1'b0;
            end else begin
              s = spop();
              spush(op == OP_DIV ? s / t : s % t);
            end
          end
          OP_SHL, OP_SHR: begin
            t = spop();
            s = mem[sp];
            if (t >= 16'd16) s = 16'd0;
            else s = (op == OP_SHL) ? (s << t) : (s >> t);
            mem[sp] = s;
          end
          OP_IOR: begin t = spop(); mem[sp] = mem[sp] | t; end
          OP_XOR: begin t = spop(); mem[sp] = mem[sp] ^ t; end
          OP_AND: begin t = spop(); mem[sp] = mem[sp] & t; end
          OP_NOT: mem[sp] = ~mem[sp];
          OP_IN: begin
            t = spop();
            if (t == 16'd0) begin
              spush(r.in_value);
              o.in_taken = 1'b1;
            end else if (t == 16'd1) begin
              o.in_index = spop();
              spush(r.in_value);
              o.in_taken = 1'b1;
              o.in_port = 1'b1;
            end else begin
              run_st = ST_BADIN;
              adv = 1'b0;
            end
          end
          OP_OUT: begin
            t = spop();
            if (t == 16'd0) begin
              s = spop();
              o.out_value = s & 16'h00FF;
              o.out_valid = 1'b1;
            end else if (t == 16'd1) begin
              o.out_index = spop();
              o.out_value = spop();
              o.out_valid = 1'b1;
              o.out_port = 1'b1;
            end else begin
              run_st = ST_BADOUT;
              adv = 1'b0;
            end
          end
          default: ;
        endcase
        if (adv) ip = ip + 16'd1;
      end
      default: ;
    endcase
    o.status = run_st;
    o.pc = ip;
    o.stack_top_addr = sp;
    o.top_word = mem[sp];
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Driver: offer the head of the pending queue, hold it until taken
  int send_gap = 0;
  always @(posedge clk) begin : drv
    bit   v;
    rsp_t e;
    v = req_valid;
    if (!rst && req_valid && !req_stall) begin
      predict_item(req, e);
      expected_rsp.push_back(e);
      void'(pend.pop_front());
      v = 1'b0;
    end
    if (!rst && !v) begin
      if (send_gap > 0) send_gap--;
      else if (pend.size() > 0) begin
        req <= pend[0];
        v = 1'b1;
        send_gap = pick_gap();
      end
    end
    req_valid <= v;
  end

  task automatic chk(string f, logic [15:0] e, logic [15:0] a);
    if (a !== e) begin
      $error("%s: expected %h, got %h", f, e, a);
      errors++;
    end
  endtask

  // Monitor: random stall, one long hold on request, check each taken result
  int  rcv_gap = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  always @(posedge clk) begin : mon
    bit   st;
    rsp_t e;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_rsp.size() == 0) begin
        $error("result item with no expectation pending");
        errors++;
      end else begin
        e = expected_rsp.pop_front();
        chk("status", 16'(e.status), 16'(rsp.status));
        chk("read_data", e.read_data, rsp.read_data);
        chk("out_valid", 16'(e.out_valid), 16'(rsp.out_valid));
        chk("out_port", 16'(e.out_port), 16'(rsp.out_port));
        chk("out_index", e.out_index, rsp.out_index);
        chk("out_value", e.out_value, rsp.out_value);
        chk("in_taken", 16'(e.in_taken), 16'(rsp.in_taken));
        chk("in_port", 16'(e.in_port), 16'(rsp.in_port));
        chk("in_index", e.in_index, rsp.in_index);
        chk("pc", e.pc, rsp.pc);
        chk("stack_top_addr", e.stack_top_addr, rsp.stack_top_addr);
        chk("top_word", e.top_word, rsp.top_word);
      end
    end
    if (hold_request && !hold_done) begin
      hold_done = 1'b1;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      st = 1'b1;
    end else if (rcv_gap > 0) begin
      rcv_gap--;
      st = 1'b1;
    end else begin
      rcv_gap = pick_gap();
      st = 1'b0;
    end
    rsp_stall <= st;
  end

  function automatic req_t mk(logic [1:0] k, logic [15:0] a, logic [15:0] lv, logic [15:0] iv);
    req_t r;
    r.req_type = k;
    r.addr = a;
    r.load_value = lv;
    r.in_value = iv;
    return r;
  endfunction

  task automatic wait_idle();
    do @(negedge clk);
    while (pend.size() != 0 || expected_rsp.size() != 0 || req_valid);
  endtask

  // Write one instruction at the predicted pc, with optional stack words, then step it
  task automatic run_op(logic [15:0] op, bit set_top, logic [15:0] top, bit set_sec,
                        logic [15:0] sec, logic [15:0] arg1, bit allow_stop);
    logic [15:0] d;
    wait_idle();
    d = sp - ip;
    if (!allow_stop && (d <= 16'd2 || d == 16'hFFFF)) begin
      set_top = 1'b0;
      set_sec = 1'b0;
      if (op == OP_DIV || op == OP_MOD || op == OP_IN || op == OP_OUT) op = OP_PUSHZ;
    end
    if (set_sec) pend.push_back(mk(REQ_LOAD, sp + 16'd1, sec, rnd16()));
    if (set_top) pend.push_back(mk(REQ_LOAD, sp, top, rnd16()));
    pend.push_back(mk(REQ_LOAD, ip, op, rnd16()));
    pend.push_back(mk(REQ_LOAD, ip + 16'd1, arg1, rnd16()));
    pend.push_back(mk(REQ_LOAD, ip + 16'd2, rnd16(), rnd16()));
    pend.push_back(mk(REQ_STEP, rnd16(), rnd16(), rnd16()));
  endtask

  logic [15:0] op_pool[$] = '{
    OP_PUSH, OP_PUSHI, OP_PUSHR, OP_PUSHA, OP_PUSHO, OP_PUSHF, OP_PUSHS, OP_PUSHP,
    OP_PUSHZ, OP_DUP, OP_POPA, OP_POPI, OP_POPR, OP_POPO, OP_POPF, OP_POPS, OP_DROP,
    OP_SWAP, OP_BRA, OP_BRI, OP_BRZ, OP_BNZ, OP_BSR, OP_RTS, OP_EQL, OP_NEQ, OP_LES,
    OP_LEQ, OP_GRE, OP_GEQ, OP_ADD, OP_INC, OP_SUB, OP_DEC, OP_MUL, OP_DIV, OP_MOD,
    OP_SHL, OP_SHR, OP_IOR, OP_XOR, OP_AND, OP_NOT, OP_IN, OP_OUT};
  logic [15:0] odd_ops[$] = '{16'h000B, 16'h0108, 16'h0202, 16'h8000, 16'hFFFF};
  logic [1:0]  side_kinds[$] = '{REQ_LOAD, REQ_READ, REQ_NONE};

  initial begin : stim
    logic [15:0] op, top, sec;
    bit st, ss;
    int k;
    for (int i = 0; i < 65536; i++) mem[i] = 16'd0;
    ip = 16'd0;
    sp = 16'hFFFF;
    fp = 16'hFFFF;
    run_st = ST_RUN;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    pend.push_back(mk(REQ_LOAD, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    pend.push_back(mk(REQ_READ, 16'hFFFF, 16'h0000, 16'h0000));
    pend.push_back(mk(REQ_READ, 16'h0000, 16'hFFFF, 16'hFFFF));
    pend.push_back(mk(REQ_NONE, 16'h5A5A, 16'hA5A5, 16'h0F0F));
    run_op(OP_PUSH, 0, 0, 0, 0, 16'hFFFF, 0);
    run_op(OP_PUSHZ, 0, 0, 0, 0, 0, 0);
    run_op(OP_SUB, 0, 0, 0, 0, 0, 0);
    run_op(OP_ADD, 1, 16'hFFFF, 1, 16'hFFFF, 0, 0);
    run_op(OP_MUL, 1, 16'hFFFF, 1, 16'hFFFF, 0, 0);
    run_op(OP_DIV, 1, 16'd3, 1, 16'hFFFF, 0, 0);
    run_op(OP_MOD, 1, 16'd7, 1, 16'hFFFF, 0, 0);
    run_op(OP_SHL, 1, 16'd15, 1, 16'h0001, 0, 0);
    run_op(OP_SHR, 1, 16'd16, 1, 16'hFFFF, 0, 0);
    run_op(OP_SHL, 1, 16'd0, 1, 16'h1234, 0, 0);
    run_op(OP_IN, 1, 16'd0, 0, 0, 0, 0);
    run_op(OP_IN, 1, 16'd1, 1, 16'hFFFF, 0, 0);
    run_op(OP_OUT, 1, 16'd0, 1, 16'h01FF, 0, 0);
    run_op(OP_OUT, 1, 16'd1, 1, 16'hFFFF, 0, 0);
    run_op(OP_LES, 1, 16'hFFFF, 1, 16'd1, 0, 0);
    run_op(OP_GEQ, 1, 16'h8000, 1, 16'h8000, 0, 0);
    run_op(OP_SWAP, 1, 16'h1111, 1, 16'h2222, 0, 0);
    run_op(OP_BSR, 0, 0, 0, 0, 16'h4000, 0);
    run_op(OP_RTS, 0, 0, 0, 0, 0, 0);
    run_op(OP_BRZ, 1, 16'd0, 0, 0, 16'h0100, 0);
    run_op(OP_BNZ, 1, 16'd0, 0, 0, 16'h0200, 0);
    run_op(16'hFFFF, 0, 0, 0, 0, 0, 0);

    k = 0;
    while (k < 1250) begin
      if (k > 600 && !hold_done) begin
        wait_idle();
        hold_request = 1'b1;
        repeat (40) begin
          pend.push_back(mk(2'($urandom_range(0, 1)), rnd16(), rnd16(), rnd16()));
          k++;
        end
      end
      if ($urandom_range(0, 9) == 0) begin
        pend.push_back(mk(side_kinds[$urandom_range(0, 2)], rnd16(), rnd16(), rnd16()));
        k++;
      end
      if ($urandom_range(0, 19) == 0) op = odd_ops[$urandom_range(0, odd_ops.size() - 1)];
      else op = op_pool[$urandom_range(0, op_pool.size() - 1)];
      wait_idle();
      st = 1'b0;
      ss = 1'b0;
      top = rnd16();
      sec = rnd16();
      case (op)
        OP_SHL, OP_SHR: if ($urandom_range(0, 3) != 0) begin
          st = 1'b1;
          top = 16'($urandom_range(0, 20));
        end
        OP_DIV, OP_MOD: if (mem[sp] == 16'd0 || $urandom_range(0, 3) == 0) begin
          st = 1'b1;
          top = $urandom_range(0, 1) ? 16'($urandom_range(1, 65535))
                                     : 16'($urandom_range(1, 9));
        end
        OP_IN, OP_OUT: begin
          st = 1'b1;
          top = 16'($urandom_range(0, 1));
        end
        OP_BRZ, OP_BNZ: begin
          st = 1'b1;
          top = $urandom_range(0, 1) ? 16'd0 : rnd16();
        end
        OP_EQL, OP_NEQ, OP_LES, OP_LEQ, OP_GRE, OP_GEQ: if ($urandom_range(0, 2) == 0) begin
          ss = 1'b1;
          sec = mem[sp];
        end
        default: ;
      endcase
      run_op(op, st, top, ss, sec, rnd16(), 0);
      k += 3 + st + ss;
      if ($urandom_range(0, 7) == 0) begin
        pend.push_back(mk(REQ_READ, ip, rnd16(), rnd16()));
        k++;
      end
    end

    case ($urandom_range(0, 3))
      0: run_op(OP_HALT, 0, 0, 0, 0, 0, 1);
      1: run_op($urandom_range(0, 1) ? OP_DIV : OP_MOD, 1, 16'd0, 0, 0, 0, 1);
      2: run_op(OP_IN, 1, 16'($urandom_range(2, 65535)), 0, 0, 0, 1);
      default: run_op(OP_OUT, 1, 16'($urandom_range(2, 65535)), 0, 0, 0, 1);
    endcase
    repeat (3) pend.push_back(mk(REQ_STEP, rnd16(), rnd16(), rnd16()));
    pend.push_back(mk(REQ_READ, rnd16(), rnd16(), rnd16()));

    wait_idle();
    repeat (50) @(posedge clk);
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
